/* rtl/core/hml_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the histogram matcher.
package hml_pkg;

    // Default sizing
    localparam int DEF_BINS       = 256;
    localparam int DEF_COUNT_BITS = 24;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int EPS_W     = 16;
    localparam int OP_W      = 3;
    localparam int PIXEL_W   = 8;
    localparam int STATUS_W  = 2;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_CNT_SRC = 3'd1,
        OP_CNT_REF = 3'd2,
        OP_BUILD   = 3'd3,
        OP_MAP     = 3'd4
    } t_op;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_MAPPED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUILT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // latch input word, reset sweep indexes
        logic clr;        // zero histogram bin at index, advance
        logic clr_map;    // also zero map entry during clear
        logic cnt_rd;     // read histograms at latched bin
        logic cnt_wr;     // write back saturated increment
        logic map_rd;     // read map at latched bin
        logic tot_rd;     // read histograms at index
        logic tot_acc;    // accumulate totals, advance
        logic cdf_rd;     // read histograms at index
        logic cdf_acc;    // running sums, start divide
        logic div_step;   // one restoring divide step
        logic cdf_wr;     // store fractions, advance
        logic zmap;       // zero map entry at index, advance
        logic m_rd;       // read both cdfs for search
        logic m_cmp;      // compare and update search
        logic out_load;   // load output register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic idx_last;
        logic div_last;
        logic tot_zero;
        logic m_fin;
        logic out_free;
    } t_dp_stat;

endpackage

/* rtl/core/hml_datapath.sv */
// Datapath: histogram, cdf and map memories, totals, dividers and match search.
module hml_datapath
    import hml_pkg::*;
#(
    parameter int BINS       = DEF_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [OP_W-1:0]     i_op,
    input  logic [PIXEL_W-1:0]  i_pixel,
    input  logic                i_mask_on,
    input  logic                i_cfg_we,
    input  logic [EPS_W-1:0]    i_cfg_wdata,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIXEL_W-1:0]  o_mapped_pixel,
    output logic [STATUS_W-1:0] o_status
);

    localparam int IDX_W = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int TOT_W = COUNT_BITS + IDX_W;
    localparam int CDF_W = FRAC_BITS + 1;
    localparam int DC_W  = $clog2(FRAC_BITS + 1);
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(BINS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Memories
    logic [COUNT_BITS-1:0] src_cnt [BINS];
    logic [COUNT_BITS-1:0] ref_cnt [BINS];
    logic [CDF_W-1:0]      src_cdf [BINS];
    logic [CDF_W-1:0]      ref_cdf [BINS];
    logic [PIXEL_W-1:0]    lmap    [BINS];

    logic [COUNT_BITS-1:0] r_src_rd, r_ref_rd;
    logic [CDF_W-1:0]      r_scdf_rd, r_rcdf_rd;
    logic [PIXEL_W-1:0]    r_map_rd;

    // Latched input word and configuration
    t_op               r_op;
    logic [IDX_W-1:0]  r_bin;
    logic              r_mask;
    logic [EPS_W-1:0]  r_eps;

    // Sweep and search indexes
    logic [IDX_W-1:0]  r_idx, r_j, r_k, r_start;

    // Totals, running sums, dividers
    logic [TOT_W-1:0]  r_tot_s, r_tot_r, r_run_s, r_run_r;
    logic [TOT_W:0]    r_rem_s, r_rem_r;
    logic [CDF_W-1:0]  r_q_s, r_q_r;
    logic [DC_W-1:0]   r_dcnt;

    logic              r_out_valid;
    logic [PIXEL_W-1:0]  r_out_pix;
    logic [STATUS_W-1:0] r_out_st;

    logic [IDX_W-1:0]  in_bin;
    logic [IDX_W-1:0]  cnt_addr;
    logic [TOT_W-1:0]  n_run_s, n_run_r;
    logic [TOT_W:0]    sh_s, sh_r;
    logic [CDF_W-1:0]  diff;
    logic              hit, k_last, j_last, tot_zero;

    // Bin of the input pixel
    always_comb begin
        if (32'(i_pixel) >= BINS) begin
            in_bin = LAST_IDX;
        end else begin
            in_bin = IDX_W'(i_pixel);
        end
    end

    assign cnt_addr = i_cmd.cnt_rd ? r_bin : r_idx;
    assign n_run_s  = r_run_s + TOT_W'(r_src_rd);
    assign n_run_r  = r_run_r + TOT_W'(r_ref_rd);
    assign sh_s     = {r_rem_s[TOT_W-1:0], 1'b0};
    assign sh_r     = {r_rem_r[TOT_W-1:0], 1'b0};
    assign tot_zero = (r_tot_s == '0) || (r_tot_r == '0);

    // Match test between source and reference fractions
    assign diff   = (r_rcdf_rd >= r_scdf_rd) ? (r_rcdf_rd - r_scdf_rd)
                                             : (r_scdf_rd - r_rcdf_rd);
    assign hit    = (32'(diff) < 32'(r_eps)) || (r_rcdf_rd > r_scdf_rd);
    assign k_last = (r_k == LAST_IDX);
    assign j_last = (r_j == LAST_IDX);

    // Histogram memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            src_cnt[r_idx] <= '0;
            ref_cnt[r_idx] <= '0;
        end else if (i_cmd.cnt_wr && r_mask) begin
            if (r_op == OP_CNT_SRC) begin
                src_cnt[r_bin] <= (r_src_rd == COUNT_MAX) ? r_src_rd : r_src_rd + 1'b1;
            end
            if (r_op == OP_CNT_REF) begin
                ref_cnt[r_bin] <= (r_ref_rd == COUNT_MAX) ? r_ref_rd : r_ref_rd + 1'b1;
            end
        end
        if (i_cmd.cnt_rd || i_cmd.tot_rd || i_cmd.cdf_rd) begin
            r_src_rd <= src_cnt[cnt_addr];
            r_ref_rd <= ref_cnt[cnt_addr];
        end
    end

    // Cdf memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.cdf_wr) begin
            src_cdf[r_idx] <= r_q_s;
            ref_cdf[r_idx] <= r_q_r;
        end
        if (i_cmd.m_rd) begin
            r_scdf_rd <= src_cdf[r_j];
            r_rcdf_rd <= ref_cdf[r_k];
        end
    end

    // Level map memory
    always_ff @(posedge i_clk) begin
        if ((i_cmd.clr && i_cmd.clr_map) || i_cmd.zmap) begin
            lmap[r_idx] <= '0;
        end else if (i_cmd.m_cmp) begin
            lmap[r_j] <= hit ? PIXEL_W'(r_k) : PIXEL_W'(LAST_IDX);
        end
        if (i_cmd.map_rd) begin
            r_map_rd <= lmap[r_bin];
        end
    end

    // Input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_bin  <= in_bin;
            r_mask <= i_mask_on;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // Sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.clr || i_cmd.tot_acc || i_cmd.cdf_wr || i_cmd.zmap) begin
            r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        end
    end

    // Totals and running sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tot_s <= '0;
            r_tot_r <= '0;
            r_run_s <= '0;
            r_run_r <= '0;
        end else if (i_cmd.tot_acc) begin
            r_tot_s <= r_tot_s + TOT_W'(r_src_rd);
            r_tot_r <= r_tot_r + TOT_W'(r_ref_rd);
        end else if (i_cmd.cdf_acc) begin
            r_run_s <= n_run_s;
            r_run_r <= n_run_r;
        end
    end

    // Restoring dividers: run * 2^FRAC_BITS / total
    always_ff @(posedge i_clk) begin
        if (i_cmd.cdf_acc) begin
            r_dcnt <= '0;
            if (n_run_s >= r_tot_s) begin
                r_q_s   <= CDF_W'(1);
                r_rem_s <= '0;
            end else begin
                r_q_s   <= '0;
                r_rem_s <= {1'b0, n_run_s};
            end
            if (n_run_r >= r_tot_r) begin
                r_q_r   <= CDF_W'(1);
                r_rem_r <= '0;
            end else begin
                r_q_r   <= '0;
                r_rem_r <= {1'b0, n_run_r};
            end
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (sh_s >= {1'b0, r_tot_s}) begin
                r_rem_s <= sh_s - {1'b0, r_tot_s};
                r_q_s   <= {r_q_s[CDF_W-2:0], 1'b1};
            end else begin
                r_rem_s <= sh_s;
                r_q_s   <= {r_q_s[CDF_W-2:0], 1'b0};
            end
            if (sh_r >= {1'b0, r_tot_r}) begin
                r_rem_r <= sh_r - {1'b0, r_tot_r};
                r_q_r   <= {r_q_r[CDF_W-2:0], 1'b1};
            end else begin
                r_rem_r <= sh_r;
                r_q_r   <= {r_q_r[CDF_W-2:0], 1'b0};
            end
        end
    end

    // Match search indexes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_j     <= '0;
            r_k     <= '0;
            r_start <= '0;
        end else if (i_cmd.m_cmp) begin
            if (hit) begin
                r_start <= r_k;
                r_j     <= r_j + 1'b1;
            end else if (k_last) begin
                r_k <= r_start;
                r_j <= r_j + 1'b1;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_op == OP_MAP) begin
                r_out_pix <= r_map_rd;
                r_out_st  <= ST_MAPPED;
            end else begin
                r_out_pix <= '0;
                r_out_st  <= tot_zero ? ST_EMPTY : ST_BUILT;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mapped_pixel = r_out_pix;
    assign o_status       = r_out_st;

    // Status to controller
    assign o_stat.idx_last = (r_idx == LAST_IDX);
    assign o_stat.div_last = (r_dcnt == DC_W'(FRAC_BITS - 1));
    assign o_stat.tot_zero = tot_zero;
    assign o_stat.m_fin    = j_last && (hit || k_last);
    assign o_stat.out_free = !r_out_valid || i_ready;

`ifndef NO_ASSERTIONS
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (32'(r_dcnt) < FRAC_BITS))
        else $error("divide stepped past fraction width");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("output register overwritten");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.m_cmp |-> (r_start <= r_k))
        else $error("search index below start");
`endif

endmodule

/* rtl/core/hml_ctrl.sv */
// Controller state machine sequencing clear, count, build and map operations.
module hml_ctrl
    import hml_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [OP_W-1:0] i_op,
    output logic            o_ready,
    output t_dp_cmd         o_cmd,
    input  t_dp_stat        i_stat
);

    typedef enum logic [15:0] {
        S_INIT    = 16'h0001,
        S_IDLE    = 16'h0002,
        S_CLR     = 16'h0004,
        S_CNT_RD  = 16'h0008,
        S_CNT_WR  = 16'h0010,
        S_MAP_RD  = 16'h0020,
        S_TOT_RD  = 16'h0040,
        S_TOT_ACC = 16'h0080,
        S_TOT_CHK = 16'h0100,
        S_CDF_RD  = 16'h0200,
        S_CDF_ACC = 16'h0400,
        S_CDF_DIV = 16'h0800,
        S_CDF_WR  = 16'h1000,
        S_ZMAP    = 16'h2000,
        S_M_RD    = 16'h4000,
        S_M_CMP   = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic   r_result;     // result pending to be loaded
    logic   n_result;

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_result = r_result;
        o_cmd    = '0;
        o_ready  = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr     = 1'b1;
                o_cmd.clr_map = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_result) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_result       = 1'b0;
                    end
                end else begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        unique case (t_op'(i_op))
                            OP_CLEAR:   n_state = S_CLR;
                            OP_CNT_SRC: n_state = S_CNT_RD;
                            OP_CNT_REF: n_state = S_CNT_RD;
                            OP_BUILD:   n_state = S_TOT_RD;
                            OP_MAP:     n_state = S_MAP_RD;
                            default:    n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_WR;
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_MAP_RD: begin
                o_cmd.map_rd = 1'b1;
                n_result     = 1'b1;
                n_state      = S_IDLE;
            end
            S_TOT_RD: begin
                o_cmd.tot_rd = 1'b1;
                n_state      = S_TOT_ACC;
            end
            S_TOT_ACC: begin
                o_cmd.tot_acc = 1'b1;
                n_state       = i_stat.idx_last ? S_TOT_CHK : S_TOT_RD;
            end
            S_TOT_CHK: begin
                n_state = i_stat.tot_zero ? S_ZMAP : S_CDF_RD;
            end
            S_CDF_RD: begin
                o_cmd.cdf_rd = 1'b1;
                n_state      = S_CDF_ACC;
            end
            S_CDF_ACC: begin
                o_cmd.cdf_acc = 1'b1;
                n_state       = S_CDF_DIV;
            end
            S_CDF_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_CDF_WR;
                end
            end
            S_CDF_WR: begin
                o_cmd.cdf_wr = 1'b1;
                n_state      = i_stat.idx_last ? S_M_RD : S_CDF_RD;
            end
            S_ZMAP: begin
                o_cmd.zmap = 1'b1;
                if (i_stat.idx_last) begin
                    n_result = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_M_RD: begin
                o_cmd.m_rd = 1'b1;
                n_state    = S_M_CMP;
            end
            S_M_CMP: begin
                o_cmd.m_cmp = 1'b1;
                if (i_stat.m_fin) begin
                    n_result = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_M_RD;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_result <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE) && !r_result)
        else $error("ready outside idle");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> !r_result)
        else $error("result flag not cleared after load");
`endif

endmodule

/* rtl/core/histogram_matching_lut_unit.sv */
// A count item reads its bin, then writes back the saturated increment; a map item reads the map,
// then loads its result; a clear zeroes every histogram bin. Build sums totals over all bins, then
// the cdf pass runs a bit-serial divider per bin and a search fills the map, up to BINS * BINS
// search steps when levels find no match. Build with an empty histogram zeroes the map instead.
// One item in work at a time; a waiting result holds off the input. Reset is synchronous, active
// low; then a pass over every bin clears histograms and map, no word taken. Epsilon resets to 1.
module histogram_matching_lut_unit
    import hml_pkg::*;
#(
    parameter int BINS       = DEF_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [PIXEL_W-1:0]  i_pixel,
    input  logic                i_mask_on,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIXEL_W-1:0]  o_mapped_pixel,
    output logic [STATUS_W-1:0] o_status,
    input  logic                i_cfg_we,
    input  logic [EPS_W-1:0]    i_cfg_wdata
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    hml_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // Memories and arithmetic
    hml_datapath #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_op           (i_op),
        .i_pixel        (i_pixel),
        .i_mask_on      (i_mask_on),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mapped_pixel (o_mapped_pixel),
        .o_status       (o_status)
    );

endmodule
